[rtl/assert_macros.svh]
// Assertion macros used by the key press classifier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/kpc_pkg.sv]
// Types and constants shared by the key press classifier modules.
`timescale 1ns / 1ps

package kpc_pkg;

    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int FUNC_W    = 2;

    localparam logic [CNT_W-1:0] LONG_TICKS_RESET = 8'd100;
    localparam logic [CNT_W-1:0] GAP_TICKS_RESET  = 8'd30;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } key_event_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_TICKS = 1'd0,
        REG_GAP_TICKS  = 1'd1
    } cfg_reg_t;

    // Per-lane command derived from one accepted transaction.
    typedef struct packed {
        logic tick;
        logic clear_one;
        logic clear_all;
    } lane_ctrl_t;

endpackage

[rtl/kpc_lane.sv]
// One key lane: debounce and hold machine, click machine and event latch.
`timescale 1ns / 1ps

module kpc_lane
    import kpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic             pressed,
    input  logic [CNT_W-1:0] long_ticks,
    input  logic [CNT_W-1:0] gap_ticks,
    output key_event_t       latched
);

    typedef enum logic [3:0] {
        DB_IDLE    = 4'b0001,
        DB_CONFIRM = 4'b0010,
        DB_HOLD    = 4'b0100,
        DB_WAIT    = 4'b1000
    } db_state_t;

    typedef enum logic [1:0] {
        CK_IDLE    = 2'b01,
        CK_PENDING = 2'b10
    } ck_state_t;

    db_state_t        db_state_reg, db_state_next;
    ck_state_t        ck_state_reg, ck_state_next;
    logic [CNT_W-1:0] hold_reg, hold_next, hold_inc;
    logic [CNT_W-1:0] gap_reg, gap_next, gap_inc;
    key_event_t       latch_reg, latch_next;
    key_event_t       base_ev, click_ev;

    assign hold_inc = hold_reg + 1'b1;
    assign gap_inc  = gap_reg + 1'b1;

    // Debounce machine: two pressed samples start the hold counter.
    always_comb
    begin
        db_state_next = db_state_reg;
        hold_next     = hold_reg;
        base_ev       = EV_NONE;
        unique case (db_state_reg)
            DB_IDLE:
            begin
                if (pressed)
                begin
                    db_state_next = DB_CONFIRM;
                end
            end
            DB_CONFIRM:
            begin
                if (pressed)
                begin
                    hold_next     = '0;
                    db_state_next = DB_HOLD;
                end
                else
                begin
                    db_state_next = DB_IDLE;
                end
            end
            DB_HOLD:
            begin
                if (!pressed)
                begin
                    base_ev       = EV_SINGLE;
                    db_state_next = DB_IDLE;
                end
                else
                begin
                    hold_next = hold_inc;
                    if (hold_inc > long_ticks)
                    begin
                        base_ev       = EV_LONG;
                        db_state_next = DB_WAIT;
                    end
                end
            end
            DB_WAIT:
            begin
                if (!pressed)
                begin
                    db_state_next = DB_IDLE;
                end
            end
            default:
            begin
                db_state_next = DB_IDLE;
            end
        endcase
    end

    // Click machine: a held single press becomes a double press or times out.
    // A long press that shows up while a click is pending is dropped.
    always_comb
    begin
        ck_state_next = ck_state_reg;
        gap_next      = gap_reg;
        click_ev      = EV_NONE;
        unique case (ck_state_reg)
            CK_IDLE:
            begin
                if (base_ev == EV_SINGLE)
                begin
                    gap_next      = '0;
                    ck_state_next = CK_PENDING;
                end
                else
                begin
                    click_ev = base_ev;
                end
            end
            CK_PENDING:
            begin
                if (base_ev == EV_SINGLE)
                begin
                    click_ev      = EV_DOUBLE;
                    ck_state_next = CK_IDLE;
                end
                else
                begin
                    gap_next = gap_inc;
                    if (gap_inc > gap_ticks)
                    begin
                        click_ev      = EV_SINGLE;
                        ck_state_next = CK_IDLE;
                    end
                end
            end
            default:
            begin
                ck_state_next = CK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        latch_next = latch_reg;
        priority if (ctrl.clear_all || ctrl.clear_one)
        begin
            latch_next = EV_NONE;
        end
        else if (ctrl.tick && (click_ev != EV_NONE))
        begin
            latch_next = click_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_state_reg <= DB_IDLE;
            ck_state_reg <= CK_IDLE;
            hold_reg     <= '0;
            gap_reg      <= '0;
            latch_reg    <= EV_NONE;
        end
        else
        begin
            if (ctrl.tick)
            begin
                db_state_reg <= db_state_next;
                ck_state_reg <= ck_state_next;
                hold_reg     <= hold_next;
                gap_reg      <= gap_next;
            end
            latch_reg <= latch_next;
        end
    end

    assign latched = latch_reg;

endmodule

[rtl/kpc_merge.sv]
// Read stage: selects one lane's latched event into the output register.
`timescale 1ns / 1ps

module kpc_merge
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = 9,
    parameter int SEL_W    = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     read_accept,
    input  logic [SEL_W-1:0]         key_select,
    input  logic [NUM_KEYS-1:0][1:0] lane_events,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [1:0]               key_event,
    output logic                     out_stall
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] key_event_reg, key_event_next;
    logic [1:0] sel_event;

    always_comb
    begin
        if (int'(key_select) < NUM_KEYS)
        begin
            sel_event = lane_events[key_select[IDX_W-1:0]];
        end
        else
        begin
            sel_event = EV_NONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        key_event_next = key_event_reg;
        priority if (read_accept)
        begin
            out_valid_next = 1'b1;
            key_event_next = sel_event;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_event_reg <= key_event_next;
    end

    assign out_valid = out_valid_reg;
    assign key_event = key_event_reg;
    assign out_stall = out_valid_reg && !out_ready;

endmodule

[rtl/key_press_classifier.sv]
// Top level of the key press classifier: one lane per key and a read stage.
// Throughput: one transaction per cycle; a tick updates every key lane at once.
// A read's result sits in the output register in the cycle after acceptance.
// Only a read waits, and only while an earlier result is still not taken downstream.
// Reset clears every lane and latch and loads thresholds 100 (long) and 30 (gap).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_press_classifier
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = 9,
    localparam int SEL_W   = ($clog2(NUM_KEYS + 1) > 4) ? $clog2(NUM_KEYS + 1) : 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [NUM_KEYS-1:0]  key_pressed,
    input  logic [SEL_W-1:0]     key_select,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           key_event,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    // Threshold registers. The configuration port never back-pressures.
    logic [CNT_W-1:0] long_ticks_reg, long_ticks_next;
    logic [CNT_W-1:0] gap_ticks_reg, gap_ticks_next;
    logic             cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb
    begin
        long_ticks_next = long_ticks_reg;
        gap_ticks_next  = gap_ticks_reg;
        if (cfg_accept)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LONG_TICKS: long_ticks_next = cfg_data;
                REG_GAP_TICKS:  gap_ticks_next  = cfg_data;
                default:        long_ticks_next = long_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg <= LONG_TICKS_RESET;
            gap_ticks_reg  <= GAP_TICKS_RESET;
        end
        else
        begin
            long_ticks_reg <= long_ticks_next;
            gap_ticks_reg  <= gap_ticks_next;
        end
    end

    // Transaction decode. A tick or a clear-all never produces a result, so
    // only a read has to wait when the output register is still occupied.
    logic in_accept;
    logic is_tick, is_read, is_clear;
    logic out_stall;

    assign is_tick   = (func == FUNC_TICK);
    assign is_read   = (func == FUNC_READ);
    assign is_clear  = (func == FUNC_CLEAR);
    assign in_ready  = !(out_stall && is_read);
    assign in_accept = in_valid && in_ready;

    // Key lanes. Each lane owns the full state of one key, so a tick moves all
    // of them at once. A read clears only the selected lane's latch.
    logic [NUM_KEYS-1:0][1:0] lane_events;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_lane
            lane_ctrl_t lane_ctrl;
            key_event_t lane_latched;

            assign lane_ctrl.tick      = in_accept && is_tick;
            assign lane_ctrl.clear_all = in_accept && is_clear;
            assign lane_ctrl.clear_one = in_accept && is_read
                                         && (int'(key_select) == k);

            kpc_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (lane_ctrl),
                .pressed    (key_pressed[k]),
                .long_ticks (long_ticks_reg),
                .gap_ticks  (gap_ticks_reg),
                .latched    (lane_latched)
            );

            assign lane_events[k] = lane_latched;
        end
    endgenerate

    // Read stage: the selected latch is captured before the lane clears it.
    kpc_merge #(
        .NUM_KEYS (NUM_KEYS),
        .SEL_W    (SEL_W)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .read_accept (in_accept && is_read),
        .key_select  (key_select),
        .lane_events (lane_events),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .key_event   (key_event),
        .out_stall   (out_stall)
    );

    // Every accepted read shows its result in the following cycle.
    `ASSERT_NEXT(a_read_gives_result, clk, rst_n, in_accept && is_read, out_valid)

    // After a clear-all transaction no lane holds an event.
    `ASSERT_NEXT(a_clear_all_empties, clk, rst_n, in_accept && is_clear, lane_events == '0)

    // The input side only stalls behind a result that is still waiting.
    `ASSERT_IMPLIES(a_stall_needs_result, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

[sim/key_press_classifier_tb.sv]
// Self-checking testbench for the key press classifier: directed and random press traffic.
`timescale 1ns / 1ps

module key_press_classifier_tb;
    import kpc_pkg::*;

    localparam int NUM_KEYS = 9;

    // Phases of the per-key debounce machine, mirrored in the predictor.
    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_CONFIRM      = 2'd1,
        PH_HOLD         = 2'd2,
        PH_RELEASE_WAIT = 2'd3
    } db_phase_t;

    // Clock, reset and all block inputs start at known values.
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func        = FUNC_TICK;
    logic [NUM_KEYS-1:0]  key_pressed = '0;
    logic [3:0]           key_select  = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           key_event;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_LONG_TICKS;
    logic [CNT_W-1:0]     cfg_data    = '0;

    // Predictor state: thresholds and one set of machines per key.
    logic [7:0]  long_ticks;
    logic [7:0]  gap_ticks;
    db_phase_t   db_phase  [NUM_KEYS];
    logic [7:0]  hold_cnt  [NUM_KEYS];
    logic        click_pend[NUM_KEYS];
    logic [7:0]  gap_cnt   [NUM_KEYS];
    key_event_t  latch     [NUM_KEYS];

    // Events that reads have been predicted to return, oldest first.
    key_event_t  read_events_q[$];

    // Idle control for both sides of the data path.
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int in_burst     = 0;

    // Press scripts for the random traffic: current level and ticks left in it.
    logic        script_level[NUM_KEYS];
    int          script_left [NUM_KEYS];

    int error_count  = 0;
    int results_seen = 0;
    int n_ticks      = 0;
    int n_reads      = 0;
    int n_clears     = 0;
    int n_cfg        = 0;
    int n_long       = 0;
    int n_double     = 0;

    key_press_classifier #(.NUM_KEYS(NUM_KEYS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key_pressed (key_pressed),
        .key_select  (key_select),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_event   (key_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard limit on the run. The slowest legal run is a few tens of microseconds,
    // so this leaves a wide margin.
    initial
    begin
        #2_000_000;
        $display("FAIL key_press_classifier");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_model();
        long_ticks = LONG_TICKS_RESET;
        gap_ticks  = GAP_TICKS_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            db_phase[k]   = PH_IDLE;
            hold_cnt[k]   = '0;
            click_pend[k] = 1'b0;
            gap_cnt[k]    = '0;
            latch[k]      = EV_NONE;
        end
    endtask

    // Debounce and hold machine of one key; yields none, single or long.
    function automatic key_event_t debounce_next(input int k, input logic pressed);
        key_event_t ev;
        ev = EV_NONE;
        case (db_phase[k])
            PH_IDLE:
            begin
                if (pressed)
                    db_phase[k] = PH_CONFIRM;
            end
            PH_CONFIRM:
            begin
                if (pressed)
                begin
                    hold_cnt[k] = '0;
                    db_phase[k] = PH_HOLD;
                end
                else
                    db_phase[k] = PH_IDLE;
            end
            PH_HOLD:
            begin
                if (!pressed)
                begin
                    ev = EV_SINGLE;
                    db_phase[k] = PH_IDLE;
                end
                else
                begin
                    // The hold counter is 8 bits and wraps, so a threshold of 255 never fires.
                    hold_cnt[k] = hold_cnt[k] + 8'd1;
                    if (hold_cnt[k] > long_ticks)
                    begin
                        ev = EV_LONG;
                        db_phase[k] = PH_RELEASE_WAIT;
                    end
                end
            end
            default:
            begin
                if (!pressed)
                    db_phase[k] = PH_IDLE;
            end
        endcase
        return ev;
    endfunction

    // Click machine: holds a single press back for the double-press gap.
    // A long press that comes while a click is pending is dropped.
    function automatic key_event_t click_next(input int k, input logic pressed);
        key_event_t base;
        key_event_t ev;
        base = debounce_next(k, pressed);
        ev   = EV_NONE;
        if (!click_pend[k])
        begin
            if (base == EV_SINGLE)
            begin
                gap_cnt[k]    = '0;
                click_pend[k] = 1'b1;
            end
            else
                ev = base;
        end
        else if (base == EV_SINGLE)
        begin
            ev = EV_DOUBLE;
            click_pend[k] = 1'b0;
        end
        else
        begin
            gap_cnt[k] = gap_cnt[k] + 8'd1;
            if (gap_cnt[k] > gap_ticks)
            begin
                ev = EV_SINGLE;
                click_pend[k] = 1'b0;
            end
        end
        return ev;
    endfunction

    // Applies one accepted transaction to the predictor.
    task automatic update_model(input func_t f, input logic [8:0] keys, input logic [3:0] sel);
        key_event_t ev;
        case (f)
            FUNC_TICK:
            begin
                n_ticks++;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    ev = click_next(k, keys[k]);
                    if (ev != EV_NONE)
                        latch[k] = ev;
                    if (ev == EV_LONG)
                        n_long++;
                    if (ev == EV_DOUBLE)
                        n_double++;
                end
            end
            FUNC_READ:
            begin
                n_reads++;
                // A read of a key that does not exist returns none and changes nothing.
                if (sel < NUM_KEYS)
                begin
                    read_events_q.push_back(latch[sel]);
                    latch[sel] = EV_NONE;
                end
                else
                    read_events_q.push_back(EV_NONE);
            end
            FUNC_CLEAR:
            begin
                n_clears++;
                for (int k = 0; k < NUM_KEYS; k++)
                    latch[k] = EV_NONE;
            end
            default:
            begin
                // The unused code does nothing and returns nothing.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one transaction. It is entered right after a rising edge and returns at
    // the edge that accepted it, with in_valid still high so that a following call
    // can keep it high without a gap.
    task automatic send_item(input func_t f, input logic [8:0] keys, input logic [3:0] sel);
        if (in_burst > 0)
            in_burst--;
        else if ($urandom_range(99) < 3)
            in_burst = $urandom_range(30, 5);
        else
        begin
            while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        func        <= f;
        key_pressed <= keys;
        key_select  <= sel;
        do
            @(posedge clk);
        while (!in_ready);
        update_model(f, keys, sel);
    endtask

    task automatic tick(input logic [8:0] keys);
        send_item(FUNC_TICK, keys, 4'($urandom_range(15)));
    endtask

    task automatic read_key(input logic [3:0] sel);
        send_item(FUNC_READ, 9'($urandom_range(511)), sel);
    endtask

    task automatic clear_all();
        send_item(FUNC_CLEAR, 9'($urandom_range(511)), 4'($urandom_range(15)));
    endtask

    // Stops sending and waits until every predicted read result has come back,
    // then keeps waiting so that nothing is left in flight inside the block.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (read_events_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes are only issued while the block is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_LONG_TICKS)
            long_ticks = val;
        else
            gap_ticks = val;
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [7:0] long_val, input logic [7:0] gap_val);
        wait_for_idle();
        write_reg(REG_LONG_TICKS, long_val);
        write_reg(REG_GAP_TICKS, gap_val);
    endtask

    // Receiver: stalls out_ready at random, with occasional stretches of no stall.
    initial
    begin : out_ready_driver
        int out_burst;
        out_burst = 0;
        forever
        begin
            @(posedge clk);
            if (out_burst > 0)
            begin
                out_burst--;
                out_ready <= 1'b1;
            end
            else if ($urandom_range(99) < 3)
            begin
                out_burst = $urandom_range(30, 5);
                out_ready <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Each result transaction is compared with the oldest predicted read event.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (read_events_q.size() == 0)
                report_mismatch($sformatf("unexpected result, key_event %0d", key_event));
            else if (key_event !== read_events_q[0])
            begin
                report_mismatch($sformatf("key_event %0d, expected %0d",
                                          key_event, read_events_q[0]));
                void'(read_events_q.pop_front());
            end
            else
                void'(read_events_q.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Latches are empty after reset; reads of missing keys and the unused code.
    task automatic test_reset_reads();
        read_key(4'd0);
        read_key(4'd8);
        read_key(4'd9);
        read_key(4'd15);
        send_item(FUNC_NOP, 9'h1FF, 4'd15);
    endtask

    // Single, double and long presses side by side, plus a long press that comes
    // while a click is pending and must be dropped. Key 0 gives a single, key 1 a
    // double, key 2 a long press and key 3 a dropped long press.
    task automatic test_press_kinds();
        set_thresholds(8'd1, 8'd5);
        tick(9'h1FF);
        tick(9'h10F);
        tick(9'h004);
        tick(9'h00E);
        tick(9'h00E);
        tick(9'h00C);
        tick(9'h00C);
        tick(9'h004);
        tick(9'h000);
        read_key(4'd0);
        read_key(4'd1);
        read_key(4'd2);
        read_key(4'd3);
        clear_all();
        read_key(4'd8);
    endtask

    // A threshold at the all-ones value makes the hold counter wrap without firing;
    // thresholds of zero fire on the first count.
    task automatic test_threshold_extremes();
        set_thresholds(8'hFF, 8'hFF);
        tick(9'h010);
        for (int i = 0; i < 262; i++)
            tick(9'h010);
        tick(9'h000);
        read_key(4'd4);
        for (int i = 0; i < 4; i++)
            tick(9'h000);
        read_key(4'd4);
        tick(9'h010);
        tick(9'h010);
        tick(9'h000);
        read_key(4'd4);

        set_thresholds(8'h00, 8'h00);
        tick(9'h020);
        tick(9'h020);
        tick(9'h020);
        read_key(4'd5);
        tick(9'h000);
        tick(9'h020);
        tick(9'h020);
        tick(9'h000);
        tick(9'h000);
        tick(9'h000);
        read_key(4'd5);
    endtask

    // Picks how many ticks a key stays at its new level in the random traffic.
    // Short runs make bounces, singles and doubles; long ones cross the thresholds.
    function automatic int pick_run(input logic pressed);
        int r;
        r = $urandom_range(99);
        if (pressed)
        begin
            if (r < 55)
                return $urandom_range(3, 1);
            else if (r < 90)
                return $urandom_range(int'(long_ticks) + 4, 1);
            else
                return $urandom_range(6, 1);
        end
        else
        begin
            if (r < 50)
                return $urandom_range(3, 1);
            else
                return $urandom_range(int'(gap_ticks) + 4, 1);
        end
    endfunction

    // Random traffic: mostly ticks that follow per-key press scripts, with some
    // noise bits, reads of real and missing keys, clear-all and the unused code.
    task automatic test_random_traffic(input logic [7:0] long_val, input logic [7:0] gap_val,
                                       input int n_items);
        int         r;
        logic [8:0] keys;
        set_thresholds(long_val, gap_val);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < 62)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (script_left[k] == 0)
                    begin
                        script_level[k] = ~script_level[k];
                        script_left[k]  = pick_run(script_level[k]);
                    end
                    script_left[k]--;
                    keys[k] = script_level[k];
                end
                if ($urandom_range(99) < 8)
                    keys[$urandom_range(NUM_KEYS - 1)] ^= 1'b1;
                if ($urandom_range(99) < 2)
                    keys = 9'($urandom_range(511));
                tick(keys);
            end
            else if (r < 94)
            begin
                if ($urandom_range(9) == 0)
                    read_key(4'($urandom_range(15, NUM_KEYS)));
                else
                    read_key(4'($urandom_range(NUM_KEYS - 1)));
            end
            else if (r < 97)
                clear_all();
            else
                send_item(FUNC_NOP, 9'($urandom_range(511)), 4'($urandom_range(15)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            script_level[k] = 1'b0;
            script_left[k]  = 0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles rarely, receiver stalls often.
        in_idle_pct  = 13;
        out_idle_pct = 66;
        test_reset_reads();
        test_press_kinds();
        test_random_traffic(8'd3, 8'd2, 300);

        // Sender idles often, receiver stalls rarely.
        in_idle_pct  = 66;
        out_idle_pct = 13;
        test_random_traffic(8'd1, 8'd1, 150);
        test_random_traffic(8'd6, 8'd3, 150);

        // No idling on either side.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_threshold_extremes();
        test_random_traffic(8'd254, 8'd254, 100);
        test_random_traffic(8'd4, 8'd4, 150);

        wait_for_idle();
        repeat (8) @(posedge clk);
        if (read_events_q.size() != 0)
            report_mismatch($sformatf("%0d read results never arrived", read_events_q.size()));

        $display("Covered %0d ticks, %0d reads, %0d clear-all, %0d register writes.",
                 n_ticks, n_reads, n_clears, n_cfg);
        $display("Checked %0d read results; predicted %0d long and %0d double presses.",
                 results_seen, n_long, n_double);
        if (error_count == 0)
            $display("PASS key_press_classifier");
        else
            $display("FAIL key_press_classifier");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/kpc_pkg.sv
rtl/kpc_lane.sv
rtl/kpc_merge.sv
rtl/key_press_classifier.sv
sim/key_press_classifier_tb.sv
